@@ hdl/cset_pkg.sv @@
// Shared types and constants for the call-stack exclusive-time profiler.
// Standalone package; used by call_stack_exclusive_time_unit.
package cset_pkg;

   localparam int FUNCTION_COUNT = 64;
   localparam int STACK_DEPTH    = 64;

   localparam int OP_W     = 2;
   localparam int ID_W     = 6;
   localparam int TS_W     = 32;
   localparam int TIME_W   = 48;
   localparam int STATUS_W = 2;

   localparam int FUNC_AW = (FUNCTION_COUNT > 1) ? $clog2(FUNCTION_COUNT) : 1;
   localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W   = $clog2(STACK_DEPTH + 1);

   // event codes; any other code reads a total
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_END   = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [ID_W-1:0] function_id;
      logic [TS_W-1:0] timestamp;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0]            result_id;
      logic signed [TIME_W-1:0]   exclusive_time;
      logic [STATUS_W-1:0]        status;
   } rsp_word_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [TS_W-1:0] start;
   } stk_entry_type;

   localparam int STK_W = $bits(stk_entry_type);

   function automatic logic [FUNC_AW-1:0] fn_addr(input logic [ID_W-1:0] id);
      return FUNC_AW'(id);
   endfunction

   function automatic logic fn_in_range(input logic [ID_W-1:0] id);
      return 32'(id) < FUNCTION_COUNT;
   endfunction

endpackage

@@ hdl/call_stack_exclusive_time_unit.sv @@
// Call-stack exclusive-time profiler, top level.
// Depends on cset_pkg and cset_ram.
//
// Usage:
// Events enter on req_ (valid/ready); each event word gives one rsp_ word.
// A start pushes (function_id, timestamp); an end pops the top entry, adds
// end - start + 1 to that function's total and subtracts it from the caller
// now on top; any other code reads one function's total.
// One event is in flight at a time. A start or a read passes from idle to
// TOT, an end on an empty stack to EMPTY, any other end through POP and SELF
// and, with a caller left on the stack, through CALLER; its result word is
// loaded in the last of these states. Each memory has one registered read
// port: the popped entry is read first, then the popped total together with
// the caller entry, then the caller total.
// The result sits in an output register; the next event is accepted while
// it waits. If the receiver stalls, the event in flight holds in its last
// step until the output register frees.
// Reset (synchronous) empties the stack and zeroes all totals at once
// through per-entry valid bits; no clearing pass is needed.
module call_stack_exclusive_time_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cset_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cset_pkg::rsp_word_type rsp_word
);
   import cset_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TOT    = 3'd1;
   localparam logic [2:0] S_EMPTY  = 3'd2;
   localparam logic [2:0] S_POP    = 3'd3;
   localparam logic [2:0] S_SELF   = 3'd4;
   localparam logic [2:0] S_CALLER = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [LVL_W-1:0]          level_ff, level_in;
   logic [FUNCTION_COUNT-1:0] tot_vld_ff, tot_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   logic [ID_W-1:0]     id_ff, id_in;
   logic [TS_W-1:0]     ts_ff, ts_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     top_id_ff, top_id_in;
   logic [ID_W-1:0]     caller_ff, caller_in;
   logic [TIME_W-1:0]   span_ff, span_in;
   logic [TIME_W-1:0]   top_new_ff, top_new_in;
   logic                tot_hit_ff, tot_hit_in;

   logic                stk_wr_en, stk_rd_en;
   logic [STK_AW-1:0]   stk_wr_addr, stk_rd_addr;
   logic [STK_W-1:0]    stk_wr_data, stk_rd_data;
   stk_entry_type       stk_rd_entry, stk_wr_entry;

   logic                tot_wr_en, tot_rd_en;
   logic [FUNC_AW-1:0]  tot_wr_addr, tot_rd_addr;
   logic [TIME_W-1:0]   tot_wr_data, tot_rd_data;

   logic                out_free;
   logic                caller_same;
   logic                top_ok;
   logic [TIME_W-1:0]   tot_val;
   logic [TIME_W-1:0]   top_new;
   logic [TIME_W-1:0]   caller_new;

   assign stk_rd_entry = stk_rd_data;
   assign stk_wr_data  = stk_wr_entry;

   cset_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   cset_ram #(.WIDTH(TIME_W), .DEPTH(FUNCTION_COUNT)) u_total_ram (
      .clock   (clock),
      .wr_en   (tot_wr_en),
      .wr_addr (tot_wr_addr),
      .wr_data (tot_wr_data),
      .rd_en   (tot_rd_en),
      .rd_addr (tot_rd_addr),
      .rd_data (tot_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      tot_vld_in   = tot_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      id_in        = id_ff;
      ts_in        = ts_ff;
      status_in    = status_ff;
      top_id_in    = top_id_ff;
      caller_in    = caller_ff;
      span_in      = span_ff;
      top_new_in   = top_new_ff;
      tot_hit_in   = tot_hit_ff;

      req_ready    = 1'b0;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = '0;
      stk_wr_entry = '0;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = '0;
      tot_wr_en    = 1'b0;
      tot_wr_addr  = '0;
      tot_wr_data  = '0;
      tot_rd_en    = 1'b0;
      tot_rd_addr  = '0;

      out_free    = !rsp_valid_ff || rsp_ready;
      caller_same = caller_ff == top_id_ff;
      top_ok      = fn_in_range(top_id_ff);
      // a never-written or out-of-range total reads as zero
      tot_val     = tot_hit_ff ? tot_rd_data : '0;
      top_new     = tot_val + span_ff;
      caller_new  = (caller_same ? top_new_ff : tot_val) - span_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               id_in = req_word.function_id;
               ts_in = req_word.timestamp;
               if (req_word.operation == OP_END) begin
                  if (level_ff == '0) begin
                     state_in = S_EMPTY;
                  end else begin
                     stk_rd_en   = 1'b1;
                     stk_rd_addr = STK_AW'(level_ff - 1'b1);
                     level_in    = level_ff - 1'b1;
                     state_in    = S_POP;
                  end
               end else begin
                  tot_rd_en   = 1'b1;
                  tot_rd_addr = fn_addr(req_word.function_id);
                  tot_hit_in  = fn_in_range(req_word.function_id) &&
                                tot_vld_ff[fn_addr(req_word.function_id)];
                  status_in   = STATUS_OK;
                  if (req_word.operation == OP_START) begin
                     if (level_ff == LVL_W'(STACK_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        stk_wr_en          = 1'b1;
                        stk_wr_addr        = STK_AW'(level_ff);
                        stk_wr_entry.id    = req_word.function_id;
                        stk_wr_entry.start = req_word.timestamp;
                        level_in           = level_ff + 1'b1;
                     end
                  end
                  state_in = S_TOT;
               end
            end
         end

         S_TOT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.result_id      = id_ff;
               rsp_word_in.exclusive_time = $signed(tot_val);
               rsp_word_in.status         = status_ff;
               state_in                   = S_IDLE;
            end
         end

         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.result_id      = '0;
               rsp_word_in.exclusive_time = '0;
               rsp_word_in.status         = STATUS_EMPTY;
               state_in                   = S_IDLE;
            end
         end

         S_POP: begin
            top_id_in   = stk_rd_entry.id;
            // wraps mod 2^48 when the end stamp precedes the start stamp
            span_in     = TIME_W'(ts_ff) - TIME_W'(stk_rd_entry.start) + TIME_W'(1);
            tot_rd_en   = 1'b1;
            tot_rd_addr = fn_addr(stk_rd_entry.id);
            tot_hit_in  = fn_in_range(stk_rd_entry.id) &&
                          tot_vld_ff[fn_addr(stk_rd_entry.id)];
            if (level_ff != '0) begin
               stk_rd_en   = 1'b1;
               stk_rd_addr = STK_AW'(level_ff - 1'b1);
            end
            state_in = S_SELF;
         end

         S_SELF: begin
            top_new_in = top_new;
            if (level_ff != '0) begin
               tot_wr_en   = top_ok;
               tot_wr_addr = fn_addr(top_id_ff);
               tot_wr_data = top_new;
               caller_in   = stk_rd_entry.id;
               // same-address read returns the old total; CALLER forwards top_new_ff
               tot_rd_en   = 1'b1;
               tot_rd_addr = fn_addr(stk_rd_entry.id);
               tot_hit_in  = fn_in_range(stk_rd_entry.id) &&
                             tot_vld_ff[fn_addr(stk_rd_entry.id)];
               state_in    = S_CALLER;
            end else if (out_free) begin
               tot_wr_en                  = top_ok;
               tot_wr_addr                = fn_addr(top_id_ff);
               tot_wr_data                = top_new;
               rsp_valid_in               = 1'b1;
               rsp_word_in.result_id      = top_id_ff;
               rsp_word_in.exclusive_time = top_ok ? $signed(top_new) : '0;
               rsp_word_in.status         = STATUS_OK;
               state_in                   = S_IDLE;
            end
         end

         S_CALLER: begin
            if (out_free) begin
               tot_wr_en             = fn_in_range(caller_ff);
               tot_wr_addr           = fn_addr(caller_ff);
               tot_wr_data           = caller_new;
               rsp_valid_in          = 1'b1;
               rsp_word_in.result_id = top_id_ff;
               if (!top_ok) begin
                  rsp_word_in.exclusive_time = '0;
               end else if (caller_same) begin
                  // recursion: the popped total is the caller total after both updates
                  rsp_word_in.exclusive_time = $signed(caller_new);
               end else begin
                  rsp_word_in.exclusive_time = $signed(top_new_ff);
               end
               rsp_word_in.status    = STATUS_OK;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (tot_wr_en) begin
         tot_vld_in[tot_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         tot_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         tot_vld_ff   <= tot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      id_ff       <= id_in;
      ts_ff       <= ts_in;
      status_ff   <= status_in;
      top_id_ff   <= top_id_in;
      caller_ff   <= caller_in;
      span_ff     <= span_in;
      top_new_ff  <= top_new_in;
      tot_hit_ff  <= tot_hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stk_wr_en |-> (level_ff < LVL_W'(STACK_DEPTH)) && (level_in == level_ff + 1'b1))
      else $error("push without room or without level increment");

   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_word.operation == OP_END && level_ff != '0)
      |=> (level_ff == $past(level_ff) - 1'b1) && (state_ff == S_POP))
      else $error("end event did not pop the stack");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == STATUS_EMPTY)
      |-> (rsp_word.result_id == '0) && (rsp_word.exclusive_time == '0))
      else $error("empty-stack response carries data");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      tot_wr_en |-> (state_ff == S_SELF || state_ff == S_CALLER))
      else $error("totals written outside an end event");
`endif

endmodule

@@ hdl/cset_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies. Read during write to the same address returns old data.
module cset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for call_stack_exclusive_time_unit: event words are predicted
// against a call-stack / exclusive-time model and compared one result word at a time.
// Depends on cset_pkg and the block's RTL only.
module tb_top;
   import cset_pkg::*;

   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, behaves as a read
   localparam int TOTAL_ITEMS = 520;
   localparam int CALM_FROM   = 450;

   class exclusive_time_scoreboard;
      logic [ID_W-1:0]   call_ids[STACK_DEPTH];
      logic [TS_W-1:0]   call_starts[STACK_DEPTH];
      int unsigned       depth_now;
      logic [TIME_W-1:0] totals[FUNCTION_COUNT];
      rsp_word_type      expected_results[$];
      int unsigned       error_count;

      function new();
         depth_now   = 0;
         error_count = 0;
         foreach (totals[i]) totals[i] = '0;
      endfunction

      function logic [TIME_W-1:0] total_of(logic [ID_W-1:0] id);
         if (int'(id) < FUNCTION_COUNT) return totals[id];
         return '0;
      endfunction

      function void add_total(logic [ID_W-1:0] id, logic [TIME_W-1:0] delta);
         if (int'(id) < FUNCTION_COUNT) totals[id] = totals[id] + delta;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // runs the profiler on one accepted event word, queues the word it must answer
      function void note_event(req_word_type w);
         rsp_word_type      r;
         logic [TIME_W-1:0] span;
         logic [ID_W-1:0]   top_id;
         r.result_id      = w.function_id;
         r.exclusive_time = '0;
         r.status         = STATUS_OK;
         case (w.operation)
            OP_START: begin
               if (depth_now >= STACK_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  call_ids[depth_now]    = w.function_id;
                  call_starts[depth_now] = w.timestamp;
                  depth_now++;
               end
               r.exclusive_time = total_of(w.function_id);
            end
            OP_END: begin
               if (depth_now == 0) begin
                  r.result_id = '0;
                  r.status    = STATUS_EMPTY;
               end else begin
                  depth_now--;
                  top_id = call_ids[depth_now];
                  // span wraps at 48 bits, so an early end stamp gives a negative span
                  span = TIME_W'(w.timestamp) - TIME_W'(call_starts[depth_now]) + TIME_W'(1);
                  add_total(top_id, span);
                  if (depth_now > 0) add_total(call_ids[depth_now - 1], TIME_W'(0) - span);
                  r.result_id      = top_id;
                  r.exclusive_time = total_of(top_id);
               end
            end
            default: begin
               r.exclusive_time = total_of(w.function_id);
            end
         endcase
         expected_results.push_back(r);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_results.size() == 0) begin
            error_count++;
            $error("result word with none pending: result_id %0d exclusive_time %0d status %0d",
                   got.result_id, got.exclusive_time, got.status);
            return;
         end
         want = expected_results.pop_front();
         if (got.result_id !== want.result_id) begin
            error_count++;
            $error("result_id expected %0d actual %0d", want.result_id, got.result_id);
         end
         if (got.exclusive_time !== want.exclusive_time) begin
            error_count++;
            $error("exclusive_time expected %0d actual %0d",
                   want.exclusive_time, got.exclusive_time);
         end
         if (got.status !== want.status) begin
            error_count++;
            $error("status expected %0d actual %0d", want.status, got.status);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   exclusive_time_scoreboard sb = new();

   int unsigned     items_sent = 0;
   int unsigned     sender_idle_pct = 10;
   bit              calm_tail = 1'b0;
   bit              hold_results = 1'b0;
   logic [TS_W-1:0] stamp_now = '0;

   call_stack_exclusive_time_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_word);
   end

   // result side: random stall bursts, one long hold on request, none in the tail
   initial begin : receiver
      int unsigned stall_pct;
      stall_pct = 10;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 199) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic logic [TS_W-1:0] next_stamp();
      if ($urandom_range(0, 19) == 0) return $urandom();
      stamp_now = stamp_now + $urandom_range(0, 2000);
      return stamp_now;
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 7));
      return ID_W'($urandom_range(0, 63));
   endfunction

   task automatic send_event(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [TS_W-1:0] ts);
      req_word_type w;
      w.operation   = op;
      w.function_id = id;
      w.timestamp   = ts;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_event(w);
      items_sent++;
      if (!calm_tail && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic unwind_calls();
      while (sb.depth_now > 0)
         send_event(OP_END, ID_W'($urandom_range(0, 63)), next_stamp());
   endtask

   // well-formed nesting with random shape, always closed back to an empty stack
   task automatic nested_calls();
      int steps;
      int pick;
      steps = $urandom_range(4, 24);
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            send_event(($urandom_range(0, 1) == 0) ? OP_READ : OP_SPARE, pick_id(), $urandom());
         else if (pick < 55 || sb.depth_now == 0)
            send_event(OP_START, pick_id(), next_stamp());
         else
            send_event(OP_END, ID_W'($urandom_range(0, 63)), next_stamp());
      end
      unwind_calls();
   endtask

   task automatic deep_calls(input int pushes);
      repeat (pushes) send_event(OP_START, pick_id(), next_stamp());
      repeat (3) send_event(OP_READ, pick_id(), $urandom());
      unwind_calls();
      repeat ($urandom_range(0, 2))
         send_event(OP_END, ID_W'($urandom_range(0, 63)), $urandom());
   endtask

   task automatic noise_events();
      repeat (8)
         send_event(OP_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 63)), $urandom());
   endtask

   initial begin : stimulus
      bit deep_done;
      bit pause_done;
      int pick;
      deep_done  = 1'b0;
      pause_done = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fresh reads, empty stack, wrap of stamps, nesting with callers
      send_event(OP_READ, 6'd0, 32'd0);
      send_event(OP_SPARE, 6'd63, 32'hFFFF_FFFF);
      send_event(OP_END, 6'd17, 32'd3);
      send_event(OP_START, 6'd63, 32'd0);
      send_event(OP_START, 6'd0, 32'd10);
      send_event(OP_END, 6'd0, 32'd5);             // ends before it started
      send_event(OP_END, 6'd0, 32'hFFFF_FFFF);
      send_event(OP_START, 6'd5, 32'd100);
      send_event(OP_START, 6'd6, 32'd200);
      send_event(OP_START, 6'd7, 32'd250);
      send_event(OP_END, 6'd63, 32'd260);
      send_event(OP_END, 6'd63, 32'd300);
      send_event(OP_END, 6'd63, 32'd400);
      send_event(OP_READ, 6'd6, 32'd0);
      send_event(OP_SPARE, 6'd5, 32'd0);
      send_event(OP_END, 6'd42, 32'd0);
      send_event(OP_START, 6'd42, 32'hFFFF_FFFF);
      send_event(OP_END, 6'd42, 32'd0);
      send_event(OP_READ, 6'd42, 32'h5A5A_A5A5);

      stamp_now = $urandom();
      while (items_sent < TOTAL_ITEMS) begin
         if (!deep_done && items_sent >= 150) begin
            // overfill the stack while the result side holds off
            hold_results = 1'b1;
            deep_calls(STACK_DEPTH + 4);
            deep_done = 1'b1;
         end else if (!pause_done && items_sent >= 300) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
            pause_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 2);
            sender_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            pick = $urandom_range(0, 9);
            if (pick < 7)
               nested_calls();
            else if (pick < 8)
               deep_calls($urandom_range(20, STACK_DEPTH + 2));
            else
               noise_events();
         end
         calm_tail = (items_sent >= CALM_FROM);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
